FILE: rtl/hlt_pkg.sv
package hlt_pkg;

  localparam int unsigned TypeW    = 2;
  localparam int unsigned AddrW    = 16;
  localparam int unsigned ProfW    = 8;
  localparam int unsigned MissW    = 8;
  localparam int unsigned ThrW     = 8;
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = ApbAddrW - 2;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);

  localparam logic [MissW-1:0]   MissCap          = 8'hFF;
  localparam logic [ThrW-1:0]    LossThrReset     = 8'd3;
  localparam logic [RegIdxW-1:0] RegLossThreshold = 1'b0;

  typedef enum logic [TypeW-1:0] {
    REQ_TICK      = 2'd0,
    REQ_HEARTBEAT = 2'd1,
    REQ_REGISTER  = 2'd2,
    REQ_REMOVE    = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [ProfW-1:0] profile;
    logic             reach;
    logic [MissW-1:0] misses;
  } slot_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic             reach;
    logic             resync;
    logic [ProfW-1:0] profile;
  } evt_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic step;
    logic last;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pend_valid;
  } dp_status_t;

endpackage

FILE: rtl/hlt_req_if.sv
interface hlt_req_if
  import hlt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [TypeW-1:0] req_type;
  logic [AddrW-1:0] node_addr;
  logic [ProfW-1:0] node_profile;
  logic             start_reachable;

  modport source (
    output valid, req_type, node_addr, node_profile, start_reachable,
    input  ready
  );
  modport sink (
    input  valid, req_type, node_addr, node_profile, start_reachable,
    output ready
  );
endinterface

FILE: rtl/hlt_evt_if.sv
interface hlt_evt_if
  import hlt_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [AddrW-1:0] event_addr;
  logic             now_reachable;
  logic             resync_request;
  logic [ProfW-1:0] event_profile;
  logic             is_last;

  modport source (
    output valid, event_addr, now_reachable, resync_request, event_profile, is_last,
    input  ready
  );
  modport sink (
    input  valid, event_addr, now_reachable, resync_request, event_profile, is_last,
    output ready
  );
endinterface

FILE: rtl/hlt_ram.sv
module hlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/hlt_ctrl.sv
module hlt_ctrl
  import hlt_pkg::*;
#(
  parameter int unsigned MaxNodes = 16,
  localparam int unsigned IdxW    = (MaxNodes > 1) ? $clog2(MaxNodes) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  dp_status_t      status_i,
  output ctrl_cmd_t       cmd_o,
  output logic [IdxW-1:0] idx_o,
  output logic [IdxW-1:0] rd_addr_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxNodes - 1);

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    rd_addr_o   = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          cmd_o.rd_en = 1'b1;
          idx_d       = '0;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (idx_q == LastIdx) begin
            cmd_o.last = 1'b1;
            state_d    = ST_FLUSH;
          end else begin
            cmd_o.rd_en = 1'b1;
            rd_addr_o   = idx_q + IdxW'(1);
            idx_d       = idx_q + IdxW'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.out_free || !status_i.pend_valid) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

FILE: rtl/hlt_dp.sv
module hlt_dp
  import hlt_pkg::*;
#(
  parameter int unsigned MaxNodes = 16,
  localparam int unsigned IdxW    = (MaxNodes > 1) ? $clog2(MaxNodes) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  input  logic [ThrW-1:0]  loss_threshold_i,
  input  logic [TypeW-1:0] req_type_i,
  input  logic [AddrW-1:0] node_addr_i,
  input  logic [ProfW-1:0] node_profile_i,
  input  logic             start_reachable_i,
  output dp_status_t       status_o,
  output logic             evt_valid_o,
  input  logic             evt_ready_i,
  output evt_t             evt_o,
  output logic             evt_last_o
);

  req_type_e        req_type_q;
  logic [AddrW-1:0] req_addr_q;
  logic [ProfW-1:0] req_prof_q;
  logic             req_start_q;

  logic [MaxNodes-1:0] used_q, used_d;
  logic                found_q, found_d;
  logic [IdxW-1:0]     found_idx_q, found_idx_d;
  logic                free_q, free_d;
  logic [IdxW-1:0]     free_idx_q, free_idx_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                pend_valid_q, pend_valid_d;
  evt_t                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  evt_t                out_q, out_d;
  logic                out_last_q, out_last_d;

  slot_t            rd;
  slot_t            wdata;
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic             used_k;
  logic             match;
  logic [MissW-1:0] mis_inc;
  logic             loss;
  logic             ev_fire;
  evt_t             ev;
  logic             out_free;

  hlt_ram #(
    .Width ($bits(slot_t)),
    .Depth (MaxNodes)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd)
  );

  assign used_k   = used_q[idx_i];
  assign match    = used_k && (rd.addr == req_addr_q) && !found_q;
  assign mis_inc  = (rd.misses == MissCap) ? rd.misses : rd.misses + MissW'(1);
  assign loss     = rd.reach && (mis_inc >= loss_threshold_i)
                    && (cnt_q != CntW'(MaxResults));
  assign out_free = !out_valid_q || evt_ready_i;

  always_comb begin
    we          = 1'b0;
    waddr       = idx_i;
    wdata       = rd;
    ev_fire     = 1'b0;
    ev          = '0;
    used_d      = used_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    free_d      = free_q;
    free_idx_d  = free_idx_q;
    if (cmd_i.step) begin
      case (req_type_q)
        REQ_TICK: begin
          if (used_k) begin
            we           = 1'b1;
            wdata.reach  = rd.reach & ~loss;
            wdata.misses = mis_inc;
            ev_fire      = loss;
            ev.addr      = rd.addr;
          end
        end
        REQ_HEARTBEAT: begin
          if (match) begin
            found_d      = 1'b1;
            we           = 1'b1;
            wdata.reach  = 1'b1;
            wdata.misses = '0;
            ev_fire      = !rd.reach;
            ev.addr      = req_addr_q;
            ev.reach     = 1'b1;
            ev.resync    = 1'b1;
            ev.profile   = rd.profile;
          end
        end
        REQ_REGISTER: begin
          if (match) begin
            found_d     = 1'b1;
            found_idx_d = idx_i;
          end
          if (!used_k && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = idx_i;
          end
          if (cmd_i.last) begin
            if (found_q) begin
              we    = 1'b1;
              waddr = found_idx_q;
            end else if (match) begin
              we = 1'b1;
            end else if (free_q) begin
              we    = 1'b1;
              waddr = free_idx_q;
            end else if (!used_k) begin
              we = 1'b1;
            end
            wdata.addr    = req_addr_q;
            wdata.profile = req_prof_q;
            wdata.reach   = req_start_q;
            wdata.misses  = '0;
            if (we) begin
              used_d[waddr] = 1'b1;
            end
          end
        end
        REQ_REMOVE: begin
          if (match) begin
            found_d        = 1'b1;
            used_d[idx_i]  = 1'b0;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.start) begin
      found_d = 1'b0;
      free_d  = 1'b0;
    end
  end

  always_comb begin
    cnt_d        = cnt_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q && !evt_ready_i;
    out_d        = out_q;
    out_last_d   = out_last_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end
    if (cmd_i.step && ev_fire) begin
      cnt_d        = cnt_q + CntW'(1);
      pend_d       = ev;
      pend_valid_d = 1'b1;
      if (pend_valid_q) begin
        out_d       = pend_q;
        out_last_d  = 1'b0;
        out_valid_d = 1'b1;
      end
    end
    if (cmd_i.flush && pend_valid_q) begin
      out_d        = pend_q;
      out_last_d   = 1'b1;
      out_valid_d  = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q       <= '0;
      found_q      <= 1'b0;
      free_q       <= 1'b0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      used_q       <= used_d;
      found_q      <= found_d;
      free_q       <= free_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_type_q  <= req_type_e'(req_type_i);
      req_addr_q  <= node_addr_i;
      req_prof_q  <= node_profile_i;
      req_start_q <= start_reachable_i;
    end
    found_idx_q <= found_idx_d;
    free_idx_q  <= free_idx_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
  end

  assign status_o.out_free   = out_free;
  assign status_o.pend_valid = pend_valid_q;
  assign evt_valid_o         = out_valid_q;
  assign evt_o               = out_q;
  assign evt_last_o          = out_last_q;

endmodule

FILE: rtl/heartbeat_loss_tracker_unit.sv
// Channel   Role   Handshake      Payload
// req_i     sink   valid/ready    req_type, node_addr, node_profile, start_reachable
// evt_o     source valid/ready    event_addr, now_reachable, resync_request,
//                                 event_profile, is_last
// apb       slave  psel/penable   loss_threshold at byte address 0
//
// Every item walks the whole slot table: ST_IDLE accepts it, ST_WALK steps through
// every slot, and ST_FLUSH releases any held event as the last one.
// The RAM's single read port sets the walk: one slot per cycle unless evt_o stalls.
// A stalled evt_o holds the walk until the waiting event is taken.
// Reset empties the table at once; no clearing pass is needed.
module heartbeat_loss_tracker_unit
  import hlt_pkg::*;
#(
  parameter int unsigned MaxNodes = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  hlt_req_if.sink             req_i,
  hlt_evt_if.source           evt_o,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  output logic [ApbDataW-1:0] prdata_o,
  output logic                pready_o
);

  localparam int unsigned IdxW = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;

  logic [ThrW-1:0] thr_q;
  logic            reg_sel;
  ctrl_cmd_t       cmd;
  dp_status_t      status;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] rd_addr;
  evt_t            evt;
  logic            evt_valid;
  logic            evt_last;

  assign pready_o = 1'b1;
  assign reg_sel  = (paddr_i[ApbAddrW-1:2] == RegLossThreshold);
  assign prdata_o = reg_sel ? ApbDataW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= LossThrReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o && reg_sel) begin
      thr_q <= pwdata_i[ThrW-1:0];
    end
  end

  hlt_ctrl #(
    .MaxNodes (MaxNodes)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .idx_o       (idx),
    .rd_addr_o   (rd_addr)
  );

  hlt_dp #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .idx_i             (idx),
    .rd_addr_i         (rd_addr),
    .loss_threshold_i  (thr_q),
    .req_type_i        (req_i.req_type),
    .node_addr_i       (req_i.node_addr),
    .node_profile_i    (req_i.node_profile),
    .start_reachable_i (req_i.start_reachable),
    .status_o          (status),
    .evt_valid_o       (evt_valid),
    .evt_ready_i       (evt_o.ready),
    .evt_o             (evt),
    .evt_last_o        (evt_last)
  );

  assign evt_o.valid          = evt_valid;
  assign evt_o.event_addr     = evt.addr;
  assign evt_o.now_reachable  = evt.reach;
  assign evt_o.resync_request = evt.resync;
  assign evt_o.event_profile  = evt.profile;
  assign evt_o.is_last        = evt_last;

endmodule

FILE: rtl/hlt_checker.sv
module hlt_checker
  import hlt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             req_valid_i,
  input logic             req_ready_i,
  input logic             evt_valid_i,
  input logic             evt_ready_i,
  input logic [AddrW-1:0] evt_addr_i,
  input logic             evt_reach_i,
  input logic             evt_resync_i,
  input logic [ProfW-1:0] evt_prof_i,
  input logic             evt_last_i
);

  a_evt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_ready_i |=> evt_valid_i && $stable(evt_addr_i)
      && $stable(evt_reach_i) && $stable(evt_resync_i) && $stable(evt_prof_i)
      && $stable(evt_last_i))
    else $error("event changed while stalled");

  a_resync_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_resync_i |-> evt_reach_i && evt_last_i)
    else $error("resync event not reachable or not last");

  a_loss_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_reach_i |-> !evt_resync_i && (evt_prof_i == '0))
    else $error("loss event carries resync or profile");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("item accepted while walk in progress");

endmodule

bind heartbeat_loss_tracker_unit hlt_checker u_hlt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .evt_valid_i  (evt_o.valid),
  .evt_ready_i  (evt_o.ready),
  .evt_addr_i   (evt_o.event_addr),
  .evt_reach_i  (evt_o.now_reachable),
  .evt_resync_i (evt_o.resync_request),
  .evt_prof_i   (evt_o.event_profile),
  .evt_last_i   (evt_o.is_last)
);
